FILE: design/u2u_pkg.sv
package u2u_pkg;

    // Configuration register indexes
    localparam logic CFG_SOURCE_FORMAT  = 1'b0;
    localparam logic CFG_OUT_BIG_ENDIAN = 1'b1;

    // Source format codes
    localparam logic [1:0] FMT_UTF8    = 2'd0;
    localparam logic [1:0] FMT_UTF16BE = 2'd1;
    localparam logic [1:0] FMT_UTF16LE = 2'd2;

    // UTF-8 lead byte tags
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Surrogate constants
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;

    // Result bytes caused by one input byte
    typedef struct packed {
        logic            has_res;
        logic [1:0]      last_idx;
        logic            bad;
        logic [3:0][7:0] data;
    } res_bundle_t;

endpackage

FILE: design/utf8_to_utf16_stream_converter_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     in_byte
// out       out_valid / out_stall   out_byte, run_last, bad_lead
// cfg       cfg_we                  cfg_index, cfg_data
//
// An input byte is registered, decoded in the next cycle and its results are
// loaded into a bundle register that sends one byte per cycle unless out_stall.
// A byte without results overlaps the output drain; a byte with results waits
// for the serializer, which sends two bytes per ASCII byte or UTF-16 pair and
// four per surrogate pair. Results pass the input, then the bundle register.
// rst_n clears handshake state, configuration and sequence state.
// out_stall holds the current result byte and backs up into in_stall.
module utf8_to_utf16_stream_converter_unit
    import u2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       bad_lead
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        bund_free;
    res_bundle_t bundle;

    assign in_stall = in_vld_reg && !advance;

    // Hold the input byte payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Track the input register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    u2u_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (in_vld_reg),
        .item_byte  (in_byte_reg),
        .bund_free  (bund_free),
        .advance    (advance),
        .bundle     (bundle)
    );

    u2u_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && bundle.has_res),
        .bundle    (bundle),
        .bund_free (bund_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .bad_lead  (bad_lead)
    );

endmodule

FILE: design/u2u_core.sv
module u2u_core
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        item_valid,
    input  logic [7:0]  item_byte,
    input  logic        bund_free,
    output logic        advance,
    output res_bundle_t bundle
);

    logic [1:0]  fmt_reg;
    logic        big_reg;
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [20:0] acc_reg, acc_next;
    logic        half_reg, half_next;
    logic [20:0] acc_shift;

    // Order the two bytes of one code unit, element 0 goes out first
    function automatic logic [1:0][7:0] unit_order(input logic [15:0] unit, input logic big);
        logic [1:0][7:0] r;
        if (big)
        begin
            r[0] = unit[15:8];
            r[1] = unit[7:0];
        end
        else
        begin
            r[0] = unit[7:0];
            r[1] = unit[15:8];
        end
        return r;
    endfunction

    // Turn a code point into one unit or a surrogate pair
    function automatic res_bundle_t emit_code(input logic [20:0] code, input logic big);
        logic [20:0] v;
        logic [15:0] hi_u;
        logic [15:0] lo_u;
        res_bundle_t r;
        r = '0;
        r.has_res = 1'b1;
        if (code > BMP_MAX)
        begin
            v = code - SUPP_BASE;
            hi_u = {5'b0, v[20:10]} + HIGH_SURR;
            lo_u = {6'b0, v[9:0]} + LOW_SURR;
            r.last_idx = 2'd3;
            r.data[1:0] = unit_order(hi_u, big);
            r.data[3:2] = unit_order(lo_u, big);
        end
        else
        begin
            r.last_idx = 2'd1;
            r.data[1:0] = unit_order(code[15:0], big);
        end
        return r;
    endfunction

    assign acc_shift = {acc_reg[14:0], item_byte[5:0]};

    // Decode one byte against the sequence state
    always_comb
    begin
        bundle          = '0;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        half_next       = half_reg;
        case (fmt_reg)
            FMT_UTF16BE, FMT_UTF16LE:
            begin
                if (!half_reg)
                begin
                    acc_next  = {13'b0, item_byte};
                    half_next = 1'b1;
                end
                else
                begin
                    half_next       = 1'b0;
                    acc_next        = '0;
                    bundle.has_res  = 1'b1;
                    bundle.last_idx = 2'd1;
                    if ((fmt_reg == FMT_UTF16BE) == big_reg)
                    begin
                        bundle.data[0] = acc_reg[7:0];
                        bundle.data[1] = item_byte;
                    end
                    else
                    begin
                        bundle.data[0] = item_byte;
                        bundle.data[1] = acc_reg[7:0];
                    end
                end
            end
            default:
            begin
                if (bytes_left_reg == 2'd0)
                begin
                    if (!item_byte[7])
                    begin
                        bundle = emit_code({13'b0, item_byte}, big_reg);
                    end
                    else if (item_byte[7:5] == LEAD2_TAG)
                    begin
                        bytes_left_next = 2'd1;
                        acc_next        = {16'b0, item_byte[4:0]};
                    end
                    else if (item_byte[7:4] == LEAD3_TAG)
                    begin
                        bytes_left_next = 2'd2;
                        acc_next        = {17'b0, item_byte[3:0]};
                    end
                    else if (item_byte[7:3] == LEAD4_TAG)
                    begin
                        bytes_left_next = 2'd3;
                        acc_next        = {18'b0, item_byte[2:0]};
                    end
                    else
                    begin
                        // Bad lead: one flagged result, drop the sequence
                        bytes_left_next = 2'd0;
                        acc_next        = '0;
                        half_next       = 1'b0;
                        bundle.has_res  = 1'b1;
                        bundle.bad      = 1'b1;
                    end
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 2'd1;
                    if (bytes_left_reg == 2'd1)
                    begin
                        bundle   = emit_code(acc_shift, big_reg);
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                    end
                end
            end
        endcase
    end

    assign advance = item_valid && (!bundle.has_res || bund_free);

    // Hold configuration and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= FMT_UTF8;
            big_reg        <= 1'b0;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            half_reg       <= 1'b0;
        end
        else if (cfg_we && cfg_index == CFG_SOURCE_FORMAT)
        begin
            fmt_reg        <= cfg_data;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            half_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_OUT_BIG_ENDIAN)
            begin
                big_reg <= cfg_data[0];
            end
            if (advance)
            begin
                bytes_left_reg <= bytes_left_next;
                acc_reg        <= acc_next;
                half_reg       <= half_next;
            end
        end
    end

endmodule

FILE: design/u2u_out_buffer.sv
module u2u_out_buffer
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_bundle_t bundle,
    output logic        bund_free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        bad_lead
);

    res_bundle_t bund_reg;
    logic        vld_reg;
    logic [1:0]  idx_reg;
    logic        last_now;

    assign last_now  = (idx_reg == bund_reg.last_idx);
    assign bund_free = !vld_reg || (!out_stall && last_now);
    assign out_valid = vld_reg;
    assign out_byte  = bund_reg.data[idx_reg];
    assign run_last  = last_now;
    assign bad_lead  = bund_reg.bad;

    // Capture the bundle payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bund_reg <= bundle;
        end
    end

    // Advance through the result bytes, one per accepted result byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (vld_reg && !out_stall)
        begin
            if (last_now)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

FILE: verif/tb_utf8_to_utf16_stream_converter_unit.sv
`timescale 1ns / 1ps

// One byte of converter output as it should appear on the result port
typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
} out_rec_t;

class transcode_board;
    logic [1:0]  fmt;
    logic        big;
    logic [1:0]  left;
    logic [20:0] acc;
    logic        half;
    out_rec_t    want_bytes[$];
    out_rec_t    batch[$];
    int          mismatches;

    function new();
        fmt = u2u_pkg::FMT_UTF8;
        big = 1'b0;
        mismatches = 0;
        clear_seq();
    endfunction

    function void clear_seq();
        left = 2'd0;
        acc = 21'd0;
        half = 1'b0;
    endfunction

    function void set_format(logic [1:0] f);
        fmt = f;
        clear_seq();
    endfunction

    function void set_order(logic b);
        big = b;
    endfunction

    function void push_byte(logic [7:0] d, logic bad);
        out_rec_t rec;
        rec.data = d;
        rec.last = 1'b0;
        rec.bad = bad;
        batch.push_back(rec);
    endfunction

    function void push_unit(logic [15:0] u);
        if (big)
        begin
            push_byte(u[15:8], 1'b0);
            push_byte(u[7:0], 1'b0);
        end
        else
        begin
            push_byte(u[7:0], 1'b0);
            push_byte(u[15:8], 1'b0);
        end
    endfunction

    // Split into a surrogate pair above the BMP, else emit one unit
    function void push_code(logic [20:0] c);
        logic [20:0] v;
        logic [31:0] hi;
        logic [31:0] lo;
        if (c > u2u_pkg::BMP_MAX)
        begin
            v = c - u2u_pkg::SUPP_BASE;
            hi = 32'(v >> 10) + 32'(u2u_pkg::HIGH_SURR);
            lo = 32'(v[9:0]) + 32'(u2u_pkg::LOW_SURR);
            push_unit(hi[15:0]);
            push_unit(lo[15:0]);
        end
        else
        begin
            push_unit(c[15:0]);
        end
    endfunction

    // Advance the converter state by one accepted request byte
    function void note_request(logic [7:0] b);
        logic [7:0] first;
        out_rec_t   rec;
        batch.delete();
        if (fmt == u2u_pkg::FMT_UTF16BE || fmt == u2u_pkg::FMT_UTF16LE)
        begin
            if (!half)
            begin
                acc = {13'd0, b};
                half = 1'b1;
            end
            else
            begin
                first = acc[7:0];
                half = 1'b0;
                acc = 21'd0;
                if ((fmt == u2u_pkg::FMT_UTF16BE) == big)
                begin
                    push_byte(first, 1'b0);
                    push_byte(b, 1'b0);
                end
                else
                begin
                    push_byte(b, 1'b0);
                    push_byte(first, 1'b0);
                end
            end
        end
        else if (left == 2'd0)
        begin
            if (!b[7])
                push_code({13'd0, b});
            else if (b[7:5] == u2u_pkg::LEAD2_TAG)
            begin
                left = 2'd1;
                acc = {16'd0, b[4:0]};
            end
            else if (b[7:4] == u2u_pkg::LEAD3_TAG)
            begin
                left = 2'd2;
                acc = {17'd0, b[3:0]};
            end
            else if (b[7:3] == u2u_pkg::LEAD4_TAG)
            begin
                left = 2'd3;
                acc = {18'd0, b[2:0]};
            end
            else
            begin
                clear_seq();
                push_byte(8'h00, 1'b1);
            end
        end
        else
        begin
            // Any byte inside a sequence counts as a continuation
            acc = {acc[14:0], b[5:0]};
            left = left - 2'd1;
            if (left == 2'd0)
            begin
                push_code(acc);
                acc = 21'd0;
            end
        end
        if (batch.size() > 0)
        begin
            rec = batch.pop_back();
            rec.last = 1'b1;
            batch.push_back(rec);
            foreach (batch[i])
                want_bytes.push_back(batch[i]);
        end
    endfunction

    // Compare one accepted result with the oldest expected byte
    function void check_result(logic [7:0] d, logic last, logic bad);
        out_rec_t w;
        if (want_bytes.size() == 0)
        begin
            $display("%0t: unexpected result out_byte %02h run_last %0b bad_lead %0b",
                     $time, d, last, bad);
            mismatches++;
            return;
        end
        w = want_bytes.pop_front();
        if (d !== w.data)
        begin
            $display("%0t: out_byte expected %02h got %02h", $time, w.data, d);
            mismatches++;
        end
        if (last !== w.last)
        begin
            $display("%0t: run_last expected %0b got %0b", $time, w.last, last);
            mismatches++;
        end
        if (bad !== w.bad)
        begin
            $display("%0t: bad_lead expected %0b got %0b", $time, w.bad, bad);
            mismatches++;
        end
    endfunction
endclass

module tb_utf8_to_utf16_stream_converter_unit;
    import u2u_pkg::*;

    localparam logic [1:0] FMT_UNUSED = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int DRAIN_CYCLES = 12;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [1:0] cfg_data = 2'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       bad_lead;

    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    int bytes_sent = 0;

    transcode_board board;

    utf8_to_utf16_stream_converter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .bad_lead  (bad_lead)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 9)) : 0;
    endfunction

    // Offer one request byte and hold it until accepted
    task automatic send_byte(logic [7:0] b);
        int  gap;
        bit  taken;
        gap = draw_gap(in_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        board.note_request(b);
        bytes_sent++;
    endtask

    task automatic send_cont();
        if ($urandom_range(0, 15) == 0)
            send_byte(8'($urandom));
        else
            send_byte({2'b10, 6'($urandom)});
    endtask

    // Mostly well-formed characters, some bad leads, truncation and noise
    task automatic send_utf8_char();
        int kind;
        int ncont;
        kind = $urandom_range(0, 11);
        ncont = 0;
        case (kind)
            0, 1, 2: send_byte({1'b0, 7'($urandom)});
            3, 4:
            begin
                send_byte({LEAD2_TAG, 5'($urandom)});
                ncont = 1;
            end
            5, 6:
            begin
                send_byte({LEAD3_TAG, 4'($urandom)});
                ncont = 2;
            end
            7, 8:
            begin
                send_byte({LEAD4_TAG, 3'($urandom)});
                ncont = 3;
            end
            9:
            begin
                if ($urandom_range(0, 1) == 1)
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
                else
                    send_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end
            default: send_byte(8'($urandom));
        endcase
        // Cut some sequences short so the next lead lands mid-sequence
        if (ncont > 0 && $urandom_range(0, 11) == 0)
            ncont = $urandom_range(0, ncont - 1);
        repeat (ncont) send_cont();
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SOURCE_FORMAT)
            board.set_format(val);
        else
            board.set_order(val[0]);
    endtask

    // Drain all expected results, then let any result-free byte finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.want_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Accept results with random stalls and check each one
    initial
    begin : result_sink
        logic       v;
        logic [7:0] d;
        logic       l;
        logic       e;
        int         gap;
        forever
        begin
            gap = draw_gap(out_idle_on);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                v = out_valid;
                d = out_byte;
                l = run_last;
                e = bad_lead;
                @(posedge clk);
            end
            while (v !== 1'b1);
            board.check_result(d, l, e);
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] directed [$];
        logic [1:0] phase_fmt [NUM_PHASES];
        logic       phase_big [NUM_PHASES];
        logic [1:0] f;
        logic       o;
        int         target;

        board = new();
        phase_fmt = '{FMT_UTF8, FMT_UTF16BE, FMT_UTF16BE, FMT_UTF16LE, FMT_UTF16LE,
                      FMT_UNUSED, FMT_UTF8, FMT_UTF8};
        phase_big = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII extremes, each form, bad leads, lead inside a sequence,
        // overlong 4 byte form, value above the Unicode range
        directed = '{8'h00, 8'h7F, 8'h41,
                     8'hC3, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'h80, 8'hBF, 8'hF8, 8'hFF,
                     8'hC2, 8'hE2,
                     8'hF0, 8'h80, 8'h80, 8'h80,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF};
        foreach (directed[i])
            send_byte(directed[i]);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            f = phase_fmt[p];
            o = phase_big[p];
            if (p == NUM_PHASES - 1)
            begin
                f = 2'($urandom_range(0, 3));
                o = 1'($urandom);
            end
            // Skip the format write now and then so state carries across
            if (f != board.fmt || $urandom_range(0, 2) == 0)
                write_reg(CFG_SOURCE_FORMAT, f);
            write_reg(CFG_OUT_BIG_ENDIAN, {1'b0, o});
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            target = bytes_sent + 40 + $urandom_range(0, 10);
            while (bytes_sent < target)
            begin
                if (board.fmt == FMT_UTF16BE || board.fmt == FMT_UTF16LE)
                    send_byte(8'($urandom));
                else
                    send_utf8_char();
            end
            wait_idle();
        end

        if (board.mismatches == 0 && board.want_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
